[sv/unsigned_divider_64_top_assert.svh]
// assertion macros shared by the divider checker
`ifndef UNSIGNED_DIVIDER_64_TOP_ASSERT_SVH
`define UNSIGNED_DIVIDER_64_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define UDIV64_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udiv64 check failed");

// next-cycle implication, disabled while in reset
`define UDIV64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udiv64 check failed");

`endif

[sv/udiv64_pkg.sv]
// shared types and constants for the 64-bit unsigned divider
package udiv64_pkg;

    // width of every operand port and of the quotient and remainder ports
    localparam int DATA_W = 64;

    typedef logic [DATA_W-1:0] data_t;

endpackage

[sv/unsigned_divider_64_top.sv]
// top level of the pipelined restoring unsigned divider
//
// usage:
//   command channel: dividend and divisor are taken on a rising edge where
//   start is high and busy is low. busy never rises, so a new transfer can
//   be issued in every cycle.
//   result channel: done is high for exactly one cycle with quotient,
//   remainder and div_by_zero valid in that same cycle. the receiver cannot
//   hold results off, and none is needed since every stage moves each cycle.
// stages: one capture stage plus one stage per quotient bit, each
//   a WIDTH+1 bit subtract and select.
// throughput: one division per cycle; the pipeline never stalls.
// operands are taken modulo 2^WIDTH; results are zero extended to 64 bits.
// a zero divisor gives div_by_zero = 1 with quotient and remainder zero.
// reset (rst_n low, asynchronous) clears the valid bits of all stages, so
// items in flight are dropped and no done pulse follows.
module unsigned_divider_64_top #(
    parameter int WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  udiv64_pkg::data_t  dividend,
    input  udiv64_pkg::data_t  divisor,
    output logic               busy,
    output logic               done,
    output udiv64_pkg::data_t  quotient,
    output udiv64_pkg::data_t  remainder,
    output logic               div_by_zero
);

    logic             valid_reg [0:WIDTH];
    logic             dbz_reg   [0:WIDTH];
    logic [WIDTH-1:0] rem_reg   [0:WIDTH];
    logic [WIDTH-1:0] nq_reg    [0:WIDTH];
    logic [WIDTH-1:0] den_reg   [0:WIDTH-1];

    logic [WIDTH-1:0] rem_next  [1:WIDTH];
    logic [WIDTH-1:0] nq_next   [1:WIDTH];

    // the pipeline never stalls
    assign busy = 1'b0;

    // capture stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        nq_reg[0]  <= dividend[WIDTH-1:0];
        den_reg[0] <= divisor[WIDTH-1:0];
        dbz_reg[0] <= (divisor[WIDTH-1:0] == '0);
    end

    // one quotient bit per stage; nq holds the unused dividend bits on top
    // and the finished quotient bits shifting in from the bottom
    for (genvar s = 0; s < WIDTH; s++)
    begin : g_stage
        logic [WIDTH:0]   shifted;
        logic [WIDTH+1:0] diff;
        logic             ge;

        always_comb
        begin
            shifted         = {rem_reg[s], nq_reg[s][WIDTH-1]};
            diff            = {1'b0, shifted} - {2'b00, den_reg[s]};
            ge              = !diff[WIDTH+1];
            rem_next[s+1]   = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            nq_next[s+1]    = {nq_reg[s][WIDTH-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= rem_next[s+1];
            nq_reg[s+1]  <= nq_next[s+1];
            dbz_reg[s+1] <= dbz_reg[s];
        end

        // the last stage has no use for the divisor after its subtract
        if (s < WIDTH - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                den_reg[s+1] <= den_reg[s];
            end
        end
    end

    assign done        = valid_reg[WIDTH];
    assign div_by_zero = dbz_reg[WIDTH];
    assign quotient    = dbz_reg[WIDTH] ? '0 : udiv64_pkg::DATA_W'(nq_reg[WIDTH]);
    assign remainder   = dbz_reg[WIDTH] ? '0 : udiv64_pkg::DATA_W'(rem_reg[WIDTH]);

endmodule

[sv/udiv64_checker.sv]
// port-level checker for the divider, bound to the top level
`include "unsigned_divider_64_top_assert.svh"

module udiv64_checker #(
    parameter int WIDTH = 64
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input udiv64_pkg::data_t  dividend,
    input udiv64_pkg::data_t  divisor,
    input logic               busy,
    input logic               done,
    input udiv64_pkg::data_t  quotient,
    input udiv64_pkg::data_t  remainder,
    input logic               div_by_zero
);

    localparam int LAT = WIDTH + 1;
    localparam udiv64_pkg::data_t OPND_MASK =
        {udiv64_pkg::DATA_W{1'b1}} >> (udiv64_pkg::DATA_W - WIDTH);

    logic               den_zero;
    logic               res_zero;
    udiv64_pkg::data_t  den_masked;
    udiv64_pkg::data_t  num_masked;

    assign den_masked = divisor & OPND_MASK;
    assign num_masked = dividend & OPND_MASK;
    assign den_zero   = (den_masked == '0);
    assign res_zero   = (quotient == '0) && (remainder == '0);

    // every result comes from an accepted transfer
    `UDIV64_ASSERT_NOW(a_done_from_transfer, clk, rst_n, done, $past(start && !busy, LAT))

    // zero flag matches the divisor of that transfer
    `UDIV64_ASSERT_NOW(a_dbz_match, clk, rst_n, done, div_by_zero == $past(den_zero, LAT))

    // zero divisor gives zero results
    `UDIV64_ASSERT_NOW(a_dbz_zero, clk, rst_n, done && div_by_zero, res_zero)

    // remainder stays below the divisor
    `UDIV64_ASSERT_NOW(a_rem_below, clk, rst_n, done && !div_by_zero, remainder < $past(den_masked, LAT))

    // remainder never exceeds the dividend
    `UDIV64_ASSERT_NOW(a_rem_le_num, clk, rst_n, done, remainder <= $past(num_masked, LAT))

endmodule

bind unsigned_divider_64_top udiv64_checker #(.WIDTH(WIDTH)) u_udiv64_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .dividend    (dividend),
    .divisor     (divisor),
    .busy        (busy),
    .done        (done),
    .quotient    (quotient),
    .remainder   (remainder),
    .div_by_zero (div_by_zero)
);

[tb/unsigned_divider_64_top_test.sv]
// self-checking testbench for the pipelined 64-bit unsigned divider
module unsigned_divider_64_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPND_W   = udiv64_pkg::DATA_W;
    localparam int LATENCY  = OPND_W + 1;
    localparam int MAX_GAP  = 40;
    localparam int PHASE_N  = 400;

    typedef struct {
        udiv64_pkg::data_t dividend;
        udiv64_pkg::data_t divisor;
        int                gap;
        logic              drain;
    } div_op_t;

    typedef struct {
        udiv64_pkg::data_t quotient;
        udiv64_pkg::data_t remainder;
        logic              div_by_zero;
    } div_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    udiv64_pkg::data_t dividend = '0;
    udiv64_pkg::data_t divisor = '0;
    logic              busy;
    logic              done;
    udiv64_pkg::data_t quotient;
    udiv64_pkg::data_t remainder;
    logic              div_by_zero;

    div_op_t     op_q[$];
    div_result_t quo_rem_q[$];
    int          err_cnt = 0;

    unsigned_divider_64_top #(
        .WIDTH(OPND_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .dividend(dividend),
        .divisor(divisor),
        .busy(busy),
        .done(done),
        .quotient(quotient),
        .remainder(remainder),
        .div_by_zero(div_by_zero)
    );

    always #5 clk = ~clk;

    // restoring shift-and-subtract with a one bit wider partial remainder
    function automatic div_result_t restoring_divide(udiv64_pkg::data_t num_in,
                                                     udiv64_pkg::data_t den_in);
        div_result_t                 res;
        udiv64_pkg::data_t           mask;
        udiv64_pkg::data_t           num;
        udiv64_pkg::data_t           den;
        logic [udiv64_pkg::DATA_W:0] part;
        udiv64_pkg::data_t           rem;
        mask = (OPND_W >= udiv64_pkg::DATA_W) ? '1 :
               ((udiv64_pkg::data_t'(1) << OPND_W) - udiv64_pkg::data_t'(1));
        num = num_in & mask;
        den = den_in & mask;
        res.quotient = '0;
        res.remainder = '0;
        res.div_by_zero = 1'b0;
        rem = '0;
        if (den == '0)
        begin
            res.div_by_zero = 1'b1;
            return res;
        end
        for (int b = OPND_W - 1; b >= 0; b--)
        begin
            part = {rem, num[b]};
            if (part >= {1'b0, den})
            begin
                part = part - {1'b0, den};
                res.quotient[b] = 1'b1;
            end
            rem = part[udiv64_pkg::DATA_W-1:0] & mask;
        end
        res.remainder = rem;
        return res;
    endfunction

    function automatic udiv64_pkg::data_t rand_operand();
        udiv64_pkg::data_t v;
        int                k;
        v = {$urandom, $urandom};
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 6))
            0, 1: v = v;
            2:    v = v >> k;
            3:    v = udiv64_pkg::data_t'($urandom_range(0, 15));
            4:    v = udiv64_pkg::data_t'(1) << k;
            5:    v = '1 >> $urandom_range(0, 2);
            default: v = (udiv64_pkg::data_t'(1) << k) -
                         udiv64_pkg::data_t'($urandom_range(0, 1));
        endcase
        return v;
    endfunction

    task automatic add_op(udiv64_pkg::data_t a, udiv64_pkg::data_t b, int gap, logic drain);
        div_op_t op;
        op.dividend = a;
        op.divisor = b;
        op.gap = gap;
        op.drain = drain;
        op_q.push_back(op);
    endtask

    // command driver: one transfer per edge where start is high and busy is low
    always @(posedge clk)
    begin : drv_blk
        logic    took;
        div_op_t op;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            took = start && !busy;
            if (took)
                quo_rem_q.push_back(restoring_divide(dividend, divisor));
            if (!start || took)
            begin
                if (op_q.size() == 0)
                begin
                    start <= 1'b0;
                end
                else if (op_q[0].drain && (quo_rem_q.size() != 0))
                begin
                    start <= 1'b0;
                end
                else if (op_q[0].gap != 0)
                begin
                    op_q[0].drain = 1'b0;
                    op_q[0].gap = op_q[0].gap - 1;
                    start <= 1'b0;
                end
                else
                begin
                    op = op_q.pop_front();
                    start <= 1'b1;
                    dividend <= op.dividend;
                    divisor <= op.divisor;
                end
            end
        end
    end

    // result monitor: done marks a one-cycle result transfer
    always @(posedge clk)
    begin : mon_blk
        div_result_t exp_res;
        if (rst_n && (done === 1'b1))
        begin
            if (quo_rem_q.size() == 0)
            begin
                $error("result with no pending division: quotient %h remainder %h",
                       quotient, remainder);
                err_cnt++;
            end
            else
            begin
                exp_res = quo_rem_q.pop_front();
                if (quotient !== exp_res.quotient)
                begin
                    $error("quotient: expected %h, actual %h", exp_res.quotient, quotient);
                    err_cnt++;
                end
                if (remainder !== exp_res.remainder)
                begin
                    $error("remainder: expected %h, actual %h", exp_res.remainder, remainder);
                    err_cnt++;
                end
                if (div_by_zero !== exp_res.div_by_zero)
                begin
                    $error("div_by_zero: expected %b, actual %b", exp_res.div_by_zero,
                           div_by_zero);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stim_blk
        int                idle_pct[4];
        int                gap;
        udiv64_pkg::data_t a;
        udiv64_pkg::data_t b;
        idle_pct = '{0, 65, 0, 19};

        // directed: extremes, zero divisor, dividend below divisor
        add_op('0, '0, 0, 1'b0);
        add_op('1, '0, 0, 1'b0);
        add_op(64'd12345, '0, 0, 1'b0);
        add_op('0, '1, 0, 1'b0);
        add_op('0, 64'd1, 0, 1'b0);
        add_op('1, '1, 0, 1'b0);
        add_op('1, 64'd1, 0, 1'b0);
        add_op('1, 64'd2, 0, 1'b0);
        add_op(64'd1, 64'd1, 0, 1'b0);
        add_op('1, 64'h8000_0000_0000_0000, 0, 1'b0);
        add_op(64'h8000_0000_0000_0000, '1, 0, 1'b0);
        add_op(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 0, 1'b0);
        add_op(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 0, 1'b0);
        add_op('1, 64'hffff_ffff_ffff_fffe, 0, 1'b0);
        add_op(64'hffff_ffff_ffff_fffe, '1, 0, 1'b0);
        add_op(64'd5, 64'd7, 0, 1'b0);
        add_op(64'd7, 64'd5, 0, 1'b0);
        add_op(64'h0123_4567_89ab_cdef, 64'h0000_0000_0000_00ff, 0, 1'b0);
        add_op(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 0, 1'b0);
        add_op(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 0, 1'b0);
        add_op(64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff, 0, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int i = 0; i < PHASE_N; i++)
            begin
                gap = 0;
                while (($urandom_range(0, 99) < idle_pct[ph]) && (gap < MAX_GAP))
                    gap++;
                a = rand_operand();
                case ($urandom_range(0, 19))
                    0:       b = '0;
                    1:       b = a;
                    2:       b = a + udiv64_pkg::data_t'(1);
                    3:       b = a >> $urandom_range(1, 63);
                    4:       b = (a >> $urandom_range(1, 63)) + udiv64_pkg::data_t'(1);
                    default: b = rand_operand();
                endcase
                // hold off until the pipeline is empty at the start of each phase and at random points
                add_op(a, b, gap, (i == 0) || ($urandom_range(0, 199) == 0));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while ((op_q.size() != 0) || start || (quo_rem_q.size() != 0))
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (quo_rem_q.size() != 0)
        begin
            $error("%0d divisions never produced a result", quo_rem_q.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
